FILE: hw/rtl/sha1bsh_pkg.sv
// Shared types and constants for the SHA-1 byte stream hasher.
package sha1bsh_pkg;

    localparam int unsigned WordW   = 32;
    localparam int unsigned Words   = 5;
    localparam int unsigned Rounds  = 80;
    localparam int unsigned BlkBytes = 64;
    localparam int unsigned LenOffs = 56;

    localparam logic [7:0] PadMark = 8'h80;

    localparam logic [Words-1:0][WordW-1:0] InitWords = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    // Command from the sequencer to the round engine
    typedef struct packed {
        logic       push;       // shift one byte into the block buffer
        logic [7:0] push_byte;
        logic       start;      // compress the buffered block
        logic       init;       // load the initial chaining words
    } t_core_cmd;

    typedef struct packed {
        logic busy;
        logic done;             // chaining words update at this edge
    } t_core_sts;

    function automatic logic [WordW-1:0] round_const(input logic [6:0] rnd);
        logic [WordW-1:0] k;
        if (rnd < 7'd20)      k = 32'h5A827999;
        else if (rnd < 7'd40) k = 32'h6ED9EBA1;
        else if (rnd < 7'd60) k = 32'h8F1BBCDC;
        else                  k = 32'hCA62C1D6;
        return k;
    endfunction

endpackage

FILE: hw/rtl/sha1bsh_core.sv
// SHA-1 round engine: block buffer / schedule window, one round per cycle.
module sha1bsh_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  sha1bsh_pkg::t_core_cmd i_cmd,
    output sha1bsh_pkg::t_core_sts o_sts,
    output logic [159:0]           o_hash
);

    typedef enum logic [1:0] {C_IDLE, C_RUN, C_ADD} t_cstate;

    t_cstate r_state;
    logic [511:0] r_win;
    logic [6:0]   r_round;
    logic [31:0]  r_a, r_b, r_c, r_d, r_e;
    logic [4:0][31:0] r_h;

    logic [31:0] w_cur, w_next, w_mix, f_val, k_val, t_val;

    // window word k sits at [511-32k -: 32]; word 0 is the current round's word
    assign w_cur  = r_win[511:480];
    assign w_mix  = r_win[95:64] ^ r_win[255:224] ^ r_win[447:416] ^ r_win[511:480];
    assign w_next = {w_mix[30:0], w_mix[31]};
    assign k_val  = sha1bsh_pkg::round_const(r_round);

    always_comb begin
        if (r_round < 7'd20) begin
            f_val = (r_b & r_c) | (~r_b & r_d);
        end else if (r_round >= 7'd40 && r_round < 7'd60) begin
            f_val = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
        end else begin
            f_val = r_b ^ r_c ^ r_d;
        end
    end

    assign t_val = {r_a[26:0], r_a[31:27]} + f_val + r_e + w_cur + k_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_round <= '0;
            r_h     <= sha1bsh_pkg::InitWords;
        end else begin
            case (r_state)
                C_IDLE: begin
                    if (i_cmd.push) begin
                        r_win <= {r_win[503:0], i_cmd.push_byte};
                    end
                    if (i_cmd.init) begin
                        r_h <= sha1bsh_pkg::InitWords;
                    end
                    if (i_cmd.start) begin
                        r_a     <= r_h[0];
                        r_b     <= r_h[1];
                        r_c     <= r_h[2];
                        r_d     <= r_h[3];
                        r_e     <= r_h[4];
                        r_round <= '0;
                        r_state <= C_RUN;
                    end
                end
                C_RUN: begin
                    r_win <= {r_win[479:0], w_next};
                    r_e   <= r_d;
                    r_d   <= r_c;
                    r_c   <= {r_b[1:0], r_b[31:2]};
                    r_b   <= r_a;
                    r_a   <= t_val;
                    if (r_round == 7'(sha1bsh_pkg::Rounds - 1)) begin
                        r_round <= '0;
                        r_state <= C_ADD;
                    end else begin
                        r_round <= r_round + 7'd1;
                    end
                end
                C_ADD: begin
                    r_h[0]  <= r_h[0] + r_a;
                    r_h[1]  <= r_h[1] + r_b;
                    r_h[2]  <= r_h[2] + r_c;
                    r_h[3]  <= r_h[3] + r_d;
                    r_h[4]  <= r_h[4] + r_e;
                    r_state <= C_IDLE;
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

    assign o_sts.busy = (r_state != C_IDLE);
    assign o_sts.done = (r_state == C_ADD);
    assign o_hash     = {r_h[0], r_h[1], r_h[2], r_h[3], r_h[4]};

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |-> r_state == C_IDLE) else $error("start while compressing");
    a_push_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> r_state == C_IDLE) else $error("byte pushed while compressing");
    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_round < 7'(sha1bsh_pkg::Rounds)) else $error("round counter out of range");
`endif

endmodule

FILE: hw/rtl/sha1_byte_stream_hasher_top.sv
// SHA-1 byte stream hasher: input sequencer, padding and digest output.
//
// Input channel (i_valid/o_ready): one message byte per item, or a bare end
// marker (i_has_byte low). The item with i_end_of_message high closes the
// message. Output channel (o_valid/i_ready): one 160-bit digest per message.
// Sequence: a byte item goes into the block buffer. The 64th byte of a block
// starts a compression (start, 80 rounds on the shared round unit, chaining
// add). The end item then pads one byte per cycle up to offset 64, hands off,
// compresses, and does so twice when fewer than nine bytes remain in the
// block; the digest is then registered once the output register is free.
// o_ready is low while padding, compressing or waiting to register a digest.
// The digest sits in an output register; a new message may start while the
// receiver stalls, but a second digest waits until the first one is taken.
// Reset: synchronous, active low; clears the byte count, the length and
// loads the initial chaining words. Nothing is pending after reset.
module sha1_byte_stream_hasher_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word_0,
    output logic [31:0] o_digest_word_1,
    output logic [31:0] o_digest_word_2,
    output logic [31:0] o_digest_word_3,
    output logic [31:0] o_digest_word_4
);

    typedef enum logic [2:0] {S_IDLE, S_PAD, S_KICK, S_WAIT, S_EMIT} t_state;
    typedef enum logic [1:0] {A_IDLE, A_PAD, A_EMIT} t_after;

    t_state r_state;
    t_after r_after;
    logic [6:0]   r_fill;
    logic [63:0]  r_len;
    logic         r_mark;
    logic         r_extra;
    logic         r_out_valid;
    logic [159:0] r_dig;

    sha1bsh_pkg::t_core_cmd core_cmd;
    sha1bsh_pkg::t_core_sts core_sts;
    logic [159:0] core_hash;

    logic       in_acc;
    logic       emit_ok;
    logic [7:0] len_byte;
    logic       pad_zero;

    assign in_acc  = i_valid && o_ready;
    assign emit_ok = !r_out_valid || i_ready;
    assign o_ready = (r_state == S_IDLE);

    // length bytes go out most significant first at offsets 56..63
    assign len_byte = r_len[8 * (7 - r_fill[2:0]) +: 8];
    assign pad_zero = r_extra || (r_fill < 7'(sha1bsh_pkg::LenOffs));

    always_comb begin
        core_cmd = '0;
        case (r_state)
            S_IDLE: begin
                core_cmd.push      = in_acc && i_has_byte;
                core_cmd.push_byte = i_data_byte;
            end
            S_PAD: begin
                if (!r_mark) begin
                    core_cmd.push      = 1'b1;
                    core_cmd.push_byte = sha1bsh_pkg::PadMark;
                end else if (r_fill != 7'(sha1bsh_pkg::BlkBytes)) begin
                    core_cmd.push      = 1'b1;
                    core_cmd.push_byte = pad_zero ? 8'h00 : len_byte;
                end
            end
            S_KICK: core_cmd.start = 1'b1;
            S_EMIT: core_cmd.init  = emit_ok;
            default: core_cmd = '0;
        endcase
    end

    sha1bsh_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (core_cmd),
        .o_sts   (core_sts),
        .o_hash  (core_hash)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_after     <= A_IDLE;
            r_fill      <= '0;
            r_len       <= '0;
            r_mark      <= 1'b0;
            r_extra     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_EMIT && emit_ok) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_mark  <= 1'b0;
                        r_extra <= 1'b0;
                        if (i_has_byte) begin
                            r_fill <= r_fill + 7'd1;
                            r_len  <= r_len + 64'd8;
                        end
                        if (i_has_byte && r_fill == 7'(sha1bsh_pkg::BlkBytes - 1)) begin
                            r_state <= S_KICK;
                            r_after <= i_end_of_message ? A_PAD : A_IDLE;
                        end else if (i_end_of_message) begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    if (!r_mark) begin
                        r_mark  <= 1'b1;
                        r_extra <= (r_fill >= 7'(sha1bsh_pkg::LenOffs));
                        r_fill  <= r_fill + 7'd1;
                    end else if (r_fill == 7'(sha1bsh_pkg::BlkBytes)) begin
                        r_state <= S_KICK;
                        r_after <= r_extra ? A_PAD : A_EMIT;
                        r_extra <= 1'b0;
                    end else begin
                        r_fill <= r_fill + 7'd1;
                    end
                end
                S_KICK: begin
                    r_fill  <= '0;
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (core_sts.done) begin
                        case (r_after)
                            A_PAD:   r_state <= S_PAD;
                            A_EMIT:  r_state <= S_EMIT;
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_EMIT: begin
                    if (emit_ok) begin
                        r_dig       <= core_hash;
                        r_len       <= '0;
                        r_fill      <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid         = r_out_valid;
    assign o_digest_word_0 = r_dig[159:128];
    assign o_digest_word_1 = r_dig[127:96];
    assign o_digest_word_2 = r_dig[95:64];
    assign o_digest_word_3 = r_dig[63:32];
    assign o_digest_word_4 = r_dig[31:0];

`ifndef SYNTHESIS
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= 7'(sha1bsh_pkg::BlkBytes)) else $error("fill index past block end");
    a_idle_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> r_fill < 7'(sha1bsh_pkg::BlkBytes))
        else $error("full block left uncompressed");
    a_busy_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_sts.busy |-> r_state == S_WAIT) else $error("sequencer moved during compression");
`endif

endmodule

FILE: verif/sha1bsh_tb_pkg.sv
// Digest tracker for the SHA-1 byte stream hasher testbench: software SHA-1 and pending digests.
package sha1bsh_tb_pkg;

    localparam int unsigned BlockBytes   = 64;
    localparam int unsigned LengthOffset = 56;
    localparam logic [7:0]  PadByte      = 8'h80;

    // index i holds digest word i (word 0 sits in the least significant 32 bits)
    typedef logic [4:0][31:0] t_digest_words;

    class sha1_digest_tracker;
        logic [7:0]    msg_block[BlockBytes];
        int unsigned   fill;
        logic [63:0]   bit_count;
        logic [31:0]   chain[5];
        t_digest_words expected_digests[$];
        int unsigned   digests_checked;
        int unsigned   error_count;

        function new();
            restart();
            digests_checked = 0;
            error_count = 0;
        endfunction

        function void restart();
            chain[0] = 32'h67452301;
            chain[1] = 32'hEFCDAB89;
            chain[2] = 32'h98BADCFE;
            chain[3] = 32'h10325476;
            chain[4] = 32'hC3D2E1F0;
            fill = 0;
            bit_count = '0;
        endfunction

        function void compress_block();
            logic [31:0] sched[16];
            logic [31:0] a, b, c, d, e, f, k, mix, t;
            int unsigned r;
            for (r = 0; r < 16; r++)
                sched[r] = {msg_block[4*r], msg_block[4*r+1], msg_block[4*r+2],
                            msg_block[4*r+3]};
            a = chain[0];
            b = chain[1];
            c = chain[2];
            d = chain[3];
            e = chain[4];
            for (r = 0; r < 80; r++) begin
                // message schedule kept as a 16-word circular window
                if (r >= 16) begin
                    mix = sched[(r + 13) % 16] ^ sched[(r + 8) % 16]
                        ^ sched[(r + 2) % 16] ^ sched[r % 16];
                    sched[r % 16] = {mix[30:0], mix[31]};
                end
                if (r < 20) begin
                    f = (b & c) | (~b & d);
                    k = 32'h5A827999;
                end else if (r < 40) begin
                    f = b ^ c ^ d;
                    k = 32'h6ED9EBA1;
                end else if (r < 60) begin
                    f = (b & c) | (b & d) | (c & d);
                    k = 32'h8F1BBCDC;
                end else begin
                    f = b ^ c ^ d;
                    k = 32'hCA62C1D6;
                end
                t = {a[26:0], a[31:27]} + f + e + sched[r % 16] + k;
                e = d;
                d = c;
                c = {b[1:0], b[31:2]};
                b = a;
                a = t;
            end
            chain[0] += a;
            chain[1] += b;
            chain[2] += c;
            chain[3] += d;
            chain[4] += e;
            fill = 0;
        endfunction

        // Called on every accepted input item
        function void absorb_item(logic [7:0] data, logic has_data, logic last);
            int unsigned i;
            if (has_data) begin
                msg_block[fill] = data;
                fill++;
                bit_count += 64'd8;
                if (fill == BlockBytes)
                    compress_block();
            end
            if (!last)
                return;
            msg_block[fill] = PadByte;
            fill++;
            // no room left for the length: pad out and spend an extra block
            if (fill > LengthOffset) begin
                while (fill < BlockBytes) begin
                    msg_block[fill] = 8'h00;
                    fill++;
                end
                compress_block();
            end
            while (fill < LengthOffset) begin
                msg_block[fill] = 8'h00;
                fill++;
            end
            for (i = 0; i < 8; i++)
                msg_block[LengthOffset + i] = bit_count[63 - 8*i -: 8];
            compress_block();
            expected_digests.push_back({chain[4], chain[3], chain[2], chain[1], chain[0]});
            restart();
        endfunction

        function int unsigned pending();
            return expected_digests.size();
        endfunction

        function void check_digest(t_digest_words got);
            t_digest_words want;
            int unsigned i;
            if (expected_digests.size() == 0) begin
                $display("%0t: unexpected digest %h, no message outstanding", $time, got);
                error_count++;
                return;
            end
            want = expected_digests.pop_front();
            digests_checked++;
            for (i = 0; i < 5; i++) begin
                if (got[i] !== want[i]) begin
                    $display("%0t: digest word %0d expected %h actual %h",
                             $time, i, want[i], got[i]);
                    error_count++;
                end
            end
        endfunction
    endclass

endpackage

FILE: verif/sha1_byte_stream_hasher_top_tb.sv
// Testbench top for the SHA-1 byte stream hasher: drives messages, checks every digest.
module sha1_byte_stream_hasher_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CycleLimit  = 1_000_000;
    localparam int unsigned StreamItems = 1300;
    localparam int unsigned QuietItems  = 150;
    localparam int unsigned DrainCycles = 320;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_has_byte = 1'b0;
    logic        i_end_of_message = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_digest_word_0;
    logic [31:0] o_digest_word_1;
    logic [31:0] o_digest_word_2;
    logic [31:0] o_digest_word_3;
    logic [31:0] o_digest_word_4;

    sha1bsh_tb_pkg::sha1_digest_tracker tracker;

    int unsigned cycle_count = 0;
    int unsigned items_sent = 0;
    int unsigned messages_sent = 0;
    int unsigned longest_msg = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned stall_left = 0;
    bit          quiet = 1'b0;

    sha1_byte_stream_hasher_top i_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Digest receiver: drops i_ready in random bursts, except in the quiet phase
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else if (!quiet && $urandom_range(99) < recv_stall_pct) begin
            stall_left = $urandom_range(2);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (i_rst_n && o_valid && i_ready && tracker != null)
            tracker.check_digest({o_digest_word_4, o_digest_word_3, o_digest_word_2,
                                  o_digest_word_1, o_digest_word_0});
        if (cycle_count > CycleLimit) begin
            $display("%0t: timeout after %0d cycles, %0d digests outstanding",
                     $time, cycle_count, tracker.pending());
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_item(input logic [7:0] data, input logic has_data, input logic last);
        int unsigned gap;
        gap = 0;
        if (!quiet && $urandom_range(99) < send_idle_pct)
            gap = $urandom_range(3, 1);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            i_data_byte <= 8'($urandom);
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data_byte <= data;
        i_has_byte <= has_data;
        i_end_of_message <= last;
        do @(posedge i_clk); while (!o_ready);
        tracker.absorb_item(data, has_data, last);
        if (has_data || last)
            items_sent++;
    endtask

    // len bytes of random content; closed by a bare end marker or by eom on the last byte
    task automatic send_message(input int unsigned len, input bit bare_end);
        int unsigned n;
        for (n = 0; n < len; n++) begin
            if ($urandom_range(99) < 4)
                send_item(8'($urandom), 1'b0, 1'b0);
            send_item(8'($urandom), 1'b1, !bare_end && n == len - 1);
        end
        if (bare_end || len == 0)
            send_item(8'($urandom), 1'b0, 1'b1);
        messages_sent++;
        if (len > longest_msg)
            longest_msg = len;
    endtask

    task automatic pick_idling();
        case ($urandom_range(3))
            0: send_idle_pct = 0;
            1: send_idle_pct = 10;
            2: send_idle_pct = 30;
            default: send_idle_pct = 60;
        endcase
        case ($urandom_range(3))
            0: recv_stall_pct = 0;
            1: recv_stall_pct = 15;
            2: recv_stall_pct = 40;
            default: recv_stall_pct = 70;
        endcase
    endtask

    initial begin
        int unsigned edge_lens[9] = '{55, 56, 57, 63, 64, 65, 119, 120, 128};
        int unsigned len;
        int unsigned pick;
        tracker = new();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 20;
        recv_stall_pct = 20;
        // empty message, twice in a row
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hFF, 1'b0, 1'b1);
        // "abc", end flag on the last byte
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        // single 0xFF byte that closes the message itself
        send_item(8'hFF, 1'b1, 1'b1);
        // zero byte, ignored idle item, then a bare end
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hA5, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        // idle item before any byte of a message
        send_item(8'h5A, 1'b0, 1'b0);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h7F, 1'b1, 1'b0);
        send_item(8'h01, 1'b1, 1'b1);
        send_item(8'h55, 1'b1, 1'b0);
        send_item(8'hAA, 1'b1, 1'b0);
        send_item(8'hFF, 1'b0, 1'b1);
        messages_sent += 7;

        // lengths around the padding boundaries
        foreach (edge_lens[i]) begin
            pick_idling();
            send_message(edge_lens[i], $urandom_range(1));
        end

        while (items_sent < StreamItems) begin
            if (items_sent >= StreamItems - QuietItems)
                quiet = 1'b1;
            pick_idling();
            pick = $urandom_range(99);
            if (pick < 55)
                len = $urandom_range(10);
            else if (pick < 85)
                len = $urandom_range(70, 50);
            else if (pick < 97)
                len = $urandom_range(40);
            else
                len = $urandom_range(200, 100);
            send_message(len, $urandom_range(1));
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        $display("Sent %0d items in %0d messages (longest %0d bytes); %0d digests compared",
                 items_sent, messages_sent, longest_msg, tracker.digests_checked);
        $display("Covered padding edges at 55-65 and 119-128 bytes, bare ends and stalls");
        if (tracker.error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
